// ===== hw/rtl/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// atce_pkg
// Shared types, codes and constants of the text cell engine.
// ----------------------------------------------------------------------------
package atce_pkg;

	// default sizes of the stores
	localparam int ROWS_MAX_DEF      = 128;
	localparam int COLS_MAX_DEF      = 256;
	localparam int HISTORY_DEPTH_DEF = 1024;

	// hard caps of the window registers
	localparam int ROWS_CAP = 128;
	localparam int COLS_CAP = 256;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_COLS = 1'b0;
	localparam logic REG_IDX_ROWS = 1'b1;
	localparam logic [8:0] COLS_RESET = 9'd80;
	localparam logic [7:0] ROWS_RESET = 8'd25;

	// cell format: {color, char}
	localparam int CHAR_W  = 7;
	localparam int COLOR_W = 4;
	localparam int CELL_W  = CHAR_W + COLOR_W;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd7;
	localparam logic [COLOR_W-1:0] COLOR_NONE  = 4'd0;

	// bytes with a meaning
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_ESC    = 8'd27;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_FIN_C  = 8'h43;
	localparam logic [7:0] CH_FIN_D  = 8'h44;
	localparam logic [7:0] CH_FIN_H  = 8'h48;
	localparam logic [7:0] CH_FIN_J  = 8'h4A;
	localparam logic [7:0] CH_FIN_K  = 8'h4B;
	localparam logic [7:0] CH_FIN_M  = 8'h6D;

	// sequence arguments
	localparam logic [31:0] ARG_ALL    = 32'd2;
	localparam logic [31:0] SGR_RESET  = 32'd0;
	localparam logic [31:0] SGR_FG_LO  = 32'd30;
	localparam logic [31:0] SGR_FG_HI  = 32'd37;
	localparam logic [31:0] SGR_BR_LO  = 32'd90;
	localparam logic [31:0] SGR_BR_HI  = 32'd97;
	localparam logic [COLOR_W-1:0] SGR_BR_BASE = 4'd8;

	typedef enum logic [1:0] {
		OP_PUT_BYTE     = 2'd0,
		OP_READ_SCREEN  = 2'd1,
		OP_READ_HISTORY = 2'd2,
		OP_CLEAR_MARKS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_SEEN = 2'd1,
		ESC_CSI  = 2'd2
	} esc_t;

	typedef enum logic [1:0] {
		SWEEP_NONE,
		SWEEP_SCROLL,
		SWEEP_FILL
	} sweep_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [8:0] ncols;
		logic [7:0] nrows;
	} cfg_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
		logic [6:0] cell_row;
		logic [7:0] cell_col;
		logic [9:0] history_line;
	} item_t;

	typedef struct packed {
		logic [6:0]  cur_row;
		logic [7:0]  cur_col;
		logic [3:0]  text_color;
		logic [1:0]  escape_phase;
		logic [6:0]  cell_char;
		logic [3:0]  cell_color;
		logic        row_dirty;
		logic        redraw_flag;
		logic [10:0] history_fill;
		logic        scrolled;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic rd_capture;
		logic copy;
		logic drain_load;
		logic fill;
		logic publish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		sweep_t sweep;
		logic   is_read;
		logic   sweep_last;
	} dp_status_t;

endpackage

// ===== hw/rtl/atce_cmd_if.sv =====
// ----------------------------------------------------------------------------
// atce_cmd_if
// Input item channel: valid/ready with the item fields.
// ----------------------------------------------------------------------------
interface atce_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [6:0] cell_row;
	logic [7:0] cell_col;
	logic [9:0] history_line;

	modport source (
		output valid, operation, data_byte, cell_row, cell_col, history_line,
		input  ready
	);
	modport sink (
		input  valid, operation, data_byte, cell_row, cell_col, history_line,
		output ready
	);
endinterface

// ===== hw/rtl/atce_rsp_if.sv =====
// ----------------------------------------------------------------------------
// atce_rsp_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface atce_rsp_if;
	logic        valid;
	logic        ready;
	logic [6:0]  cur_row;
	logic [7:0]  cur_col;
	logic [3:0]  text_color;
	logic [1:0]  escape_phase;
	logic [6:0]  cell_char;
	logic [3:0]  cell_color;
	logic        row_dirty;
	logic        redraw_flag;
	logic [10:0] history_fill;
	logic        scrolled;

	modport source (
		output valid, cur_row, cur_col, text_color, escape_phase, cell_char,
		       cell_color, row_dirty, redraw_flag, history_fill, scrolled,
		input  ready
	);
	modport sink (
		input  valid, cur_row, cur_col, text_color, escape_phase, cell_char,
		       cell_color, row_dirty, redraw_flag, history_fill, scrolled,
		output ready
	);
endinterface

// ===== hw/rtl/atce_ram.sv =====
// ----------------------------------------------------------------------------
// atce_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module atce_ram #(
	parameter  int WIDTH = 11,
	parameter  int DEPTH = 2,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/atce_cfg.sv =====
// ----------------------------------------------------------------------------
// atce_cfg
// APB register file for the window size; hands out the clamped sizes.
// ----------------------------------------------------------------------------
module atce_cfg #(
	parameter int ROWS_MAX = atce_pkg::ROWS_MAX_DEF,
	parameter int COLS_MAX = atce_pkg::COLS_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [atce_pkg::PADDR_W-1:0] paddr,
	input  logic [atce_pkg::PDATA_W-1:0] pwdata,
	output logic [atce_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output atce_pkg::cfg_t               cfg
);

	localparam int COLS_TOP = (COLS_MAX < atce_pkg::COLS_CAP) ? COLS_MAX : atce_pkg::COLS_CAP;
	localparam int ROWS_TOP = (ROWS_MAX < atce_pkg::ROWS_CAP) ? ROWS_MAX : atce_pkg::ROWS_CAP;

	logic [8:0] cols_q;
	logic [7:0] rows_q;
	logic       wr_en;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= atce_pkg::COLS_RESET;
			rows_q <= atce_pkg::ROWS_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				atce_pkg::REG_IDX_COLS: cols_q <= pwdata[8:0];
				atce_pkg::REG_IDX_ROWS: rows_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		unique case (reg_idx)
			atce_pkg::REG_IDX_COLS: prdata = {23'd0, cols_q};
			atce_pkg::REG_IDX_ROWS: prdata = {24'd0, rows_q};
			default:                prdata = '0;
		endcase
	end

	// window size in use, clamped to 1..min(MAX, cap)
	always_comb begin
		if (cols_q == 9'd0)
			cfg.ncols = 9'd1;
		else if (cols_q > 9'(COLS_TOP))
			cfg.ncols = 9'(COLS_TOP);
		else
			cfg.ncols = cols_q;
		if (rows_q == 8'd0)
			cfg.nrows = 8'd1;
		else if (rows_q > 8'(ROWS_TOP))
			cfg.nrows = 8'(ROWS_TOP);
		else
			cfg.nrows = rows_q;
	end

endmodule

// ===== hw/rtl/atce_ctrl.sv =====
// ----------------------------------------------------------------------------
// atce_ctrl
// Sequencer: item intake, exec, read wait, scroll copy, fill sweeps, result.
// ----------------------------------------------------------------------------
module atce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  atce_pkg::dp_status_t status,
	output atce_pkg::dp_cmd_t    dp_cmd
);

	atce_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	// state and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= atce_pkg::ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.publish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		dp_cmd    = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			atce_pkg::ST_INIT: begin
				dp_cmd.fill = 1'b1;
				if (status.sweep_last)
					state_d = atce_pkg::ST_IDLE;
			end
			atce_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					dp_cmd.accept = 1'b1;
					state_d       = atce_pkg::ST_EXEC;
				end
			end
			atce_pkg::ST_EXEC: begin
				dp_cmd.exec = 1'b1;
				if (status.is_read)
					state_d = atce_pkg::ST_RDWAIT;
				else if (status.sweep == atce_pkg::SWEEP_SCROLL)
					state_d = atce_pkg::ST_COPY;
				else if (status.sweep == atce_pkg::SWEEP_FILL)
					state_d = atce_pkg::ST_FILL;
				else
					state_d = atce_pkg::ST_DONE;
			end
			atce_pkg::ST_RDWAIT: begin
				dp_cmd.rd_capture = 1'b1;
				state_d           = atce_pkg::ST_DONE;
			end
			atce_pkg::ST_COPY: begin
				dp_cmd.copy = 1'b1;
				if (status.sweep_last)
					state_d = atce_pkg::ST_DRAIN;
			end
			atce_pkg::ST_DRAIN: begin
				dp_cmd.drain_load = 1'b1;
				state_d           = atce_pkg::ST_FILL;
			end
			atce_pkg::ST_FILL: begin
				dp_cmd.fill = 1'b1;
				if (status.sweep_last)
					state_d = atce_pkg::ST_DONE;
			end
			atce_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					dp_cmd.publish = 1'b1;
					state_d        = atce_pkg::ST_IDLE;
				end
			end
			default: state_d = atce_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/atce_dp.sv =====
// ----------------------------------------------------------------------------
// atce_dp
// Datapath: terminal state, byte interpreter, screen and history RAMs,
// sweep counters for scroll and clear, result register.
// ----------------------------------------------------------------------------
module atce_dp #(
	parameter int ROWS_MAX      = atce_pkg::ROWS_MAX_DEF,
	parameter int COLS_MAX      = atce_pkg::COLS_MAX_DEF,
	parameter int HISTORY_DEPTH = atce_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  atce_pkg::cfg_t       cfg,
	input  atce_pkg::item_t      item,
	input  atce_pkg::dp_cmd_t    dp_cmd,
	output atce_pkg::dp_status_t status,
	output atce_pkg::result_t    result
);

	localparam int RW        = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
	localparam int CW        = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
	localparam int HW        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
	localparam int SW        = HW + 1;
	localparam int LSW       = ((HW > 10) ? HW : 10) + 1;
	localparam int SCR_DEPTH = ROWS_MAX * (2 ** CW);
	localparam int HIS_DEPTH = HISTORY_DEPTH * (2 ** CW);
	localparam int SCR_AW    = (SCR_DEPTH > 1) ? $clog2(SCR_DEPTH) : 1;
	localparam int HIS_AW    = (HIS_DEPTH > 1) ? $clog2(HIS_DEPTH) : 1;
	localparam int CELL_W    = atce_pkg::CELL_W;

	localparam logic [CELL_W-1:0] CELL_NONE = {atce_pkg::COLOR_NONE, atce_pkg::CH_SPACE[6:0]};

	// latched item and terminal state
	atce_pkg::item_t            item_q;
	logic [6:0]                 row_q;
	logic [7:0]                 col_q;
	logic [3:0]                 color_q;
	atce_pkg::esc_t             esc_q;
	logic [31:0]                num_q;
	logic [ROWS_MAX-1:0]        marks_q;
	logic                       redraw_q;
	logic [HW-1:0]              head_q;
	logic [CNT_W-1:0]           count_q;
	logic [HW-1:0]              hslot_q;
	logic                       pushed_q;
	logic [CELL_W-1:0]          cell_q;
	atce_pkg::result_t          res_q;

	// sweep counters and bounds
	logic [RW-1:0] sw_row_q;
	logic [CW-1:0] sw_col_q;
	logic [RW-1:0] fill_lo_q;
	logic [RW-1:0] fill_hi_q;
	logic [CW-1:0] col_last_q;

	// scroll copy pipeline
	logic          copy_v_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	// effective cursor and window
	logic [7:0] nr;
	logic [8:0] nc;
	logic [6:0] er;
	logic [7:0] ec;

	// byte interpreter results
	logic [7:0]            db;
	logic [6:0]            n_row;
	logic [7:0]            n_col;
	logic [3:0]            n_color;
	atce_pkg::esc_t        n_esc;
	logic [31:0]           n_num;
	logic                  ma_en;
	logic                  mb_en;
	logic [6:0]            mb;
	logic                  m_all;
	atce_pkg::sweep_t      kind;
	logic                  put_en;
	logic                  do_lf;
	logic [RW-1:0]         n_lo;
	logic [RW-1:0]         n_hi;
	logic [7:0]            lf_row1;
	logic [8:0]            col1;
	logic [31:0]           num10;
	logic [31:0]           step_n;
	logic [8:0]            room;
	logic [ROWS_MAX-1:0]   marks_n;

	// history ring
	logic [SW-1:0]   hsum;
	logic [HW-1:0]   hslot_n;
	logic            hist_full;
	logic [LSW-1:0]  lsum;
	logic [HW-1:0]   rd_slot;
	logic            scr_ok;
	logic            his_ok;

	// memory ports
	logic              scr_we;
	logic [SCR_AW-1:0] scr_waddr;
	logic [CELL_W-1:0] scr_wdata;
	logic [SCR_AW-1:0] scr_raddr;
	logic [CELL_W-1:0] scr_rdata;
	logic              his_we;
	logic [HIS_AW-1:0] his_waddr;
	logic [HIS_AW-1:0] his_raddr;
	logic [CELL_W-1:0] his_rdata;
	logic              sweep_last;

	assign nr = cfg.nrows;
	assign nc = cfg.ncols;
	assign er = ({1'b0, row_q} >= nr) ? 7'(nr - 8'd1) : row_q;
	assign ec = ({1'b0, col_q} >= nc) ? 8'(nc - 9'd1) : col_q;
	assign db = item_q.data_byte;

	assign lf_row1 = {1'b0, er} + 8'd1;
	assign col1    = {1'b0, ec} + 9'd1;
	assign num10   = (num_q << 3) + (num_q << 1) + {24'd0, db - atce_pkg::CH_DIG0};
	assign step_n  = (num_q == 32'd0) ? 32'd1 : num_q;
	assign room    = nc - 9'd1 - {1'b0, ec};

	// byte interpreter for a put-byte item
	always_comb begin
		n_row   = er;
		n_col   = ec;
		n_color = color_q;
		n_esc   = esc_q;
		n_num   = num_q;
		ma_en   = 1'b0;
		mb_en   = 1'b0;
		mb      = er;
		m_all   = 1'b0;
		kind    = atce_pkg::SWEEP_NONE;
		put_en  = 1'b0;
		do_lf   = 1'b0;
		n_lo    = RW'(nr - 8'd1);
		n_hi    = RW'(nr - 8'd1);
		unique case (esc_q)
			atce_pkg::ESC_SEEN: begin
				n_esc = (db == atce_pkg::CH_LBRACK) ? atce_pkg::ESC_CSI : atce_pkg::ESC_NONE;
				n_num = 32'd0;
			end
			atce_pkg::ESC_CSI: begin
				if (db >= atce_pkg::CH_DIG0 && db <= atce_pkg::CH_DIG9) begin
					n_num = num10;
				end else if (db != atce_pkg::CH_SEMI) begin
					n_esc = atce_pkg::ESC_NONE;
					unique case (db)
						atce_pkg::CH_FIN_J: begin
							if (num_q == atce_pkg::ARG_ALL) begin
								kind  = atce_pkg::SWEEP_FILL;
								n_lo  = '0;
								n_row = 7'd0;
								n_col = 8'd0;
								m_all = 1'b1;
							end
						end
						atce_pkg::CH_FIN_K: begin
							if (num_q == atce_pkg::ARG_ALL) begin
								kind  = atce_pkg::SWEEP_FILL;
								n_lo  = RW'(er);
								n_hi  = RW'(er);
								n_col = 8'd0;
								ma_en = 1'b1;
							end
						end
						atce_pkg::CH_FIN_M: begin
							if (num_q == atce_pkg::SGR_RESET)
								n_color = atce_pkg::COLOR_RESET;
							else if (num_q >= atce_pkg::SGR_FG_LO && num_q <= atce_pkg::SGR_FG_HI)
								n_color = 4'(num_q - atce_pkg::SGR_FG_LO);
							else if (num_q >= atce_pkg::SGR_BR_LO && num_q <= atce_pkg::SGR_BR_HI)
								n_color = 4'(num_q - atce_pkg::SGR_BR_LO) + atce_pkg::SGR_BR_BASE;
						end
						atce_pkg::CH_FIN_H: begin
							ma_en = 1'b1;
							mb_en = 1'b1;
							mb    = 7'd0;
							n_row = 7'd0;
							n_col = 8'd0;
						end
						atce_pkg::CH_FIN_C: begin
							ma_en = 1'b1;
							if (step_n > {23'd0, room})
								n_col = 8'(nc - 9'd1);
							else
								n_col = ec + step_n[7:0];
						end
						atce_pkg::CH_FIN_D: begin
							ma_en = 1'b1;
							if (step_n > {24'd0, ec})
								n_col = 8'd0;
							else
								n_col = ec - step_n[7:0];
						end
						default: ;
					endcase
				end
			end
			default: begin
				unique case (db)
					atce_pkg::CH_ESC: n_esc = atce_pkg::ESC_SEEN;
					atce_pkg::CH_CR: begin
						ma_en = 1'b1;
						n_col = 8'd0;
					end
					atce_pkg::CH_LF: do_lf = 1'b1;
					atce_pkg::CH_BS: begin
						ma_en = 1'b1;
						if (ec != 8'd0)
							n_col = ec - 8'd1;
					end
					default: begin
						if (db >= atce_pkg::CH_SPACE && db < atce_pkg::CH_DEL) begin
							ma_en  = 1'b1;
							put_en = 1'b1;
							if (col1 >= nc)
								do_lf = 1'b1;
							else
								n_col = col1[7:0];
						end
					end
				endcase
			end
		endcase
		// new line, scrolling at the bottom
		if (do_lf) begin
			ma_en = 1'b1;
			n_col = 8'd0;
			if (lf_row1 >= nr) begin
				n_row = 7'(nr - 8'd1);
				m_all = 1'b1;
				kind  = atce_pkg::SWEEP_SCROLL;
			end else begin
				n_row = 7'(lf_row1);
				mb_en = 1'b1;
				mb    = 7'(lf_row1);
			end
		end
	end

	// dirty marks after the byte
	always_comb begin
		for (int r = 0; r < ROWS_MAX; r++) begin
			marks_n[r] = marks_q[r]
				| (m_all && (r < nr))
				| (ma_en && !redraw_q && (er == r) && (r < nr))
				| (mb_en && !redraw_q && (mb == r) && (r < nr));
		end
	end

	// history slot for a push, and the slot of a history read
	assign hsum      = SW'(head_q) + SW'(count_q);
	assign hslot_n   = (hsum >= SW'(HISTORY_DEPTH)) ? HW'(hsum - SW'(HISTORY_DEPTH)) : HW'(hsum);
	assign hist_full = (count_q == CNT_W'(HISTORY_DEPTH));
	assign lsum      = LSW'(head_q) + LSW'(item_q.history_line);
	assign rd_slot   = (lsum >= LSW'(HISTORY_DEPTH)) ? HW'(lsum - LSW'(HISTORY_DEPTH)) : HW'(lsum);
	assign scr_ok    = (item_q.cell_row < nr) && (item_q.cell_col < nc);
	assign his_ok    = (item_q.history_line < count_q) && (item_q.cell_col < nc);

	assign sweep_last = (sw_row_q == fill_hi_q) && (sw_col_q == col_last_q);

	// status to the controller
	always_comb begin
		status.sweep      = (item_q.operation == atce_pkg::OP_PUT_BYTE) ? kind
		                                                                : atce_pkg::SWEEP_NONE;
		status.is_read    = (item_q.operation == atce_pkg::OP_READ_SCREEN)
		                 || (item_q.operation == atce_pkg::OP_READ_HISTORY);
		status.sweep_last = sweep_last;
	end

	// screen RAM ports
	always_comb begin
		scr_we    = 1'b0;
		scr_waddr = SCR_AW'({sw_row_q, sw_col_q});
		scr_wdata = {color_q, atce_pkg::CH_SPACE[6:0]};
		if (dp_cmd.exec && item_q.operation == atce_pkg::OP_PUT_BYTE && put_en) begin
			scr_we    = 1'b1;
			scr_waddr = SCR_AW'({RW'(er), CW'(ec)});
			scr_wdata = {color_q, db[6:0]};
		end else if (copy_v_s1 && row_s1 != '0) begin
			scr_we    = 1'b1;
			scr_waddr = SCR_AW'({row_s1 - RW'(1), col_s1});
			scr_wdata = scr_rdata;
		end else if (dp_cmd.fill) begin
			scr_we = 1'b1;
		end
		if (dp_cmd.copy)
			scr_raddr = SCR_AW'({sw_row_q, sw_col_q});
		else
			scr_raddr = SCR_AW'({RW'(item_q.cell_row), CW'(item_q.cell_col)});
	end

	// history RAM ports: top row goes in during the scroll copy
	assign his_we    = copy_v_s1 && (row_s1 == '0);
	assign his_waddr = HIS_AW'({hslot_q, col_s1});
	assign his_raddr = HIS_AW'({rd_slot, CW'(item_q.cell_col)});

	atce_ram #(.WIDTH(CELL_W), .DEPTH(SCR_DEPTH)) u_screen_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	atce_ram #(.WIDTH(CELL_W), .DEPTH(HIS_DEPTH)) u_history_ram (
		.clk   (clk),
		.we    (his_we),
		.waddr (his_waddr),
		.wdata (scr_rdata),
		.raddr (his_raddr),
		.rdata (his_rdata)
	);

	// item latch
	always_ff @(posedge clk) begin
		if (dp_cmd.accept)
			item_q <= item;
	end

	// terminal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= 7'd0;
			col_q    <= 8'd0;
			color_q  <= atce_pkg::COLOR_RESET;
			esc_q    <= atce_pkg::ESC_NONE;
			num_q    <= 32'd0;
			marks_q  <= '0;
			redraw_q <= 1'b0;
			head_q   <= '0;
			count_q  <= '0;
			hslot_q  <= '0;
			pushed_q <= 1'b0;
		end else if (dp_cmd.exec) begin
			pushed_q <= 1'b0;
			case (item_q.operation)
				atce_pkg::OP_PUT_BYTE: begin
					row_q    <= n_row;
					col_q    <= n_col;
					color_q  <= n_color;
					esc_q    <= n_esc;
					num_q    <= n_num;
					marks_q  <= marks_n;
					redraw_q <= redraw_q | m_all;
					if (kind == atce_pkg::SWEEP_SCROLL) begin
						pushed_q <= 1'b1;
						if (!hist_full) begin
							hslot_q <= hslot_n;
							count_q <= count_q + CNT_W'(1);
						end else begin
							hslot_q <= head_q;
							head_q  <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);
						end
					end
				end
				atce_pkg::OP_CLEAR_MARKS: begin
					marks_q  <= '0;
					redraw_q <= 1'b0;
				end
				default: ;
			endcase
		end else begin
			// keep the cursor inside the window after a size change
			row_q <= er;
			col_q <= ec;
		end
	end

	// sweep counters and bounds; reset bounds cover all ROWS_MAX x COLS_MAX cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_row_q   <= '0;
			sw_col_q   <= '0;
			fill_lo_q  <= '0;
			fill_hi_q  <= RW'(ROWS_MAX - 1);
			col_last_q <= CW'(COLS_MAX - 1);
			copy_v_s1  <= 1'b0;
		end else begin
			copy_v_s1 <= dp_cmd.copy;
			if (dp_cmd.exec) begin
				fill_lo_q  <= n_lo;
				fill_hi_q  <= n_hi;
				col_last_q <= CW'(nc - 9'd1);
				sw_row_q   <= (kind == atce_pkg::SWEEP_SCROLL) ? '0 : n_lo;
				sw_col_q   <= '0;
			end else if (dp_cmd.drain_load) begin
				sw_row_q <= fill_lo_q;
				sw_col_q <= '0;
			end else if (dp_cmd.copy || dp_cmd.fill) begin
				if (sw_col_q == col_last_q) begin
					sw_col_q <= '0;
					sw_row_q <= sw_row_q + RW'(1);
				end else begin
					sw_col_q <= sw_col_q + CW'(1);
				end
			end
		end
	end

	// copy pipeline address, and the cell read for the result
	always_ff @(posedge clk) begin
		row_s1 <= sw_row_q;
		col_s1 <= sw_col_q;
		if (dp_cmd.exec)
			cell_q <= CELL_NONE;
		else if (dp_cmd.rd_capture) begin
			if (item_q.operation == atce_pkg::OP_READ_SCREEN)
				cell_q <= scr_ok ? scr_rdata : CELL_NONE;
			else
				cell_q <= his_ok ? his_rdata : CELL_NONE;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (dp_cmd.publish) begin
			res_q.cur_row      <= er;
			res_q.cur_col      <= ec;
			res_q.text_color   <= color_q;
			res_q.escape_phase <= esc_q;
			res_q.cell_char    <= cell_q[6:0];
			res_q.cell_color   <= cell_q[CELL_W-1:7];
			res_q.row_dirty    <= (item_q.cell_row < ROWS_MAX) ? marks_q[RW'(item_q.cell_row)]
			                                                   : 1'b0;
			res_q.redraw_flag  <= redraw_q;
			res_q.history_fill <= 11'(count_q);
			res_q.scrolled     <= pushed_q;
		end
	end

	assign result = res_q;

endmodule

// ===== hw/rtl/ansi_text_cell_engine.sv =====
// ----------------------------------------------------------------------------
// ansi_text_cell_engine
// Character-cell terminal: byte interpreter, screen, scrollback, cell reads.
// ----------------------------------------------------------------------------
// Scroll: one screen RAM read and write a cycle while the rows move up,
// then a fill of the bottom row; clear screen and clear line are fill sweeps.
// One item at a time; the next is taken while the result waits in its register.
// After reset a clearing pass writes ROWS_MAX*COLS_MAX cells of the screen
// store (32768 at defaults) before the first item is taken.
module ansi_text_cell_engine #(
	parameter int ROWS_MAX      = atce_pkg::ROWS_MAX_DEF,
	parameter int COLS_MAX      = atce_pkg::COLS_MAX_DEF,
	parameter int HISTORY_DEPTH = atce_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	atce_cmd_if.sink                     cmd,
	atce_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [atce_pkg::PADDR_W-1:0] paddr,
	input  logic [atce_pkg::PDATA_W-1:0] pwdata,
	output logic [atce_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	atce_pkg::cfg_t       cfg;
	atce_pkg::item_t      item;
	atce_pkg::result_t    result;
	atce_pkg::dp_cmd_t    dp_cmd;
	atce_pkg::dp_status_t status;

	// input fields into the item struct
	always_comb begin
		item.operation    = atce_pkg::op_t'(cmd.operation);
		item.data_byte    = cmd.data_byte;
		item.cell_row     = cmd.cell_row;
		item.cell_col     = cmd.cell_col;
		item.history_line = cmd.history_line;
	end

	atce_cfg #(.ROWS_MAX(ROWS_MAX), .COLS_MAX(COLS_MAX)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	atce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	atce_dp #(
		.ROWS_MAX      (ROWS_MAX),
		.COLS_MAX      (COLS_MAX),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.dp_cmd (dp_cmd),
		.status (status),
		.result (result)
	);

	// result fields onto the channel
	assign rsp.cur_row      = result.cur_row;
	assign rsp.cur_col      = result.cur_col;
	assign rsp.text_color   = result.text_color;
	assign rsp.escape_phase = result.escape_phase;
	assign rsp.cell_char    = result.cell_char;
	assign rsp.cell_color   = result.cell_color;
	assign rsp.row_dirty    = result.row_dirty;
	assign rsp.redraw_flag  = result.redraw_flag;
	assign rsp.history_fill = result.history_fill;
	assign rsp.scrolled     = result.scrolled;

endmodule
